// ----- sv/sdta_pkg.sv -----
package sdta_pkg;

  localparam int MAG_BITS   = 64;
  localparam int NUM_DIGITS = 20;
  localparam int STEP_W     = $clog2(MAG_BITS);
  localparam int DIG_W      = $clog2(NUM_DIGITS);
  localparam int CHAR_W     = 6;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] ASCII_MINUS = CHAR_W'(45);

  // One classified item: sign and unsigned magnitude.
  typedef struct packed {
    logic                neg;
    logic [MAG_BITS-1:0] mag;
  } fr_item_t;

  typedef logic [NUM_DIGITS-1:0][3:0] digits_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CONV,
    BK_SCAN,
    BK_SIGN,
    BK_DIGIT
  } bk_state_t;

endpackage

// ----- sv/sdta_front.sv -----
module sdta_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic signed [63:0]            value,
  output logic                          item_valid,
  output sdta_pkg::fr_item_t            item,
  input  logic                          take
);
  import sdta_pkg::*;

  fr_item_t   ent [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push_ok;
  fr_item_t   cls;

  assign full       = (count == 2'd2);
  assign push_ok    = push && !full;
  assign item_valid = (count != 2'd0);
  assign item       = ent[rd_ptr];

  // Split into sign and magnitude; the most negative value wraps to 2^63.
  always_comb begin
    cls.neg = value[63];
    cls.mag = value[63] ? (~value + 64'd1) : value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push_ok) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push_ok, take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      ent[wr_ptr] <= cls;
    end
  end

endmodule

// ----- sv/sdta_back.sv -----
module sdta_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  sdta_pkg::fr_item_t            item,
  output logic                          take,
  output logic                          empty,
  input  logic                          pop,
  output logic [sdta_pkg::CHAR_W-1:0]   character,
  output logic                          last
);
  import sdta_pkg::*;

  bk_state_t           state;
  bk_state_t           state_next;
  logic [MAG_BITS-1:0] mag;
  logic                neg;
  digits_t             bcd;
  digits_t             adj;
  digits_t             bcd_next;
  logic [NUM_DIGITS*4:0] sh;
  logic [STEP_W-1:0]   step;
  logic [DIG_W-1:0]    idx;
  logic [DIG_W-1:0]    lead;
  logic [3:0]          cur_digit;

  // Output queue, two beats deep.
  logic [CHAR_W-1:0]   oq_char [2];
  logic                oq_last [2];
  logic [1:0]          oq_count;
  logic                oq_wr;
  logic                oq_rd;
  logic                oq_full;
  logic                oq_push;
  logic                oq_pop;
  logic [CHAR_W-1:0]   push_char;
  logic                push_last;

  // Double dabble step: add 3 to every digit of 5 or more, then shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (bcd[i] >= 4'd5) ? (bcd[i] + 4'd3) : bcd[i];
    end
    sh       = {adj, mag[MAG_BITS-1]};
    bcd_next = sh[NUM_DIGITS*4-1:0];
  end

  // Most significant nonzero digit; zero yields digit 0.
  always_comb begin
    lead = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i] != 4'd0) begin
        lead = DIG_W'(i);
      end
    end
  end

  assign cur_digit = bcd[idx];

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:  if (item_valid) state_next = BK_CONV;
      BK_CONV:  if (step == STEP_W'(MAG_BITS - 1)) state_next = BK_SCAN;
      BK_SCAN:  state_next = neg ? BK_SIGN : BK_DIGIT;
      BK_SIGN:  if (!oq_full) state_next = BK_DIGIT;
      BK_DIGIT: if (!oq_full && idx == '0) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    take      = 1'b0;
    oq_push   = 1'b0;
    push_char = ASCII_ZERO + {2'b00, cur_digit};
    push_last = 1'b0;
    case (state)
      BK_IDLE:  take = item_valid;
      BK_SIGN: begin
        oq_push   = !oq_full;
        push_char = ASCII_MINUS;
      end
      BK_DIGIT: begin
        oq_push   = !oq_full;
        push_last = (idx == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mag  <= item.mag;
      neg  <= item.neg;
      bcd  <= '0;
      step <= '0;
    end else if (state == BK_CONV) begin
      mag  <= mag << 1;
      bcd  <= bcd_next;
      step <= step + STEP_W'(1);
    end
    if (state == BK_SCAN) begin
      idx <= lead;
    end else if (state == BK_DIGIT && oq_push) begin
      idx <= idx - DIG_W'(1);
    end
  end

  assign oq_full   = (oq_count == 2'd2);
  assign empty     = (oq_count == 2'd0);
  assign oq_pop    = pop && !empty;
  assign character = oq_char[oq_rd];
  assign last      = oq_last[oq_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_count <= 2'd0;
      oq_wr    <= 1'b0;
      oq_rd    <= 1'b0;
    end else begin
      if (oq_push) begin
        oq_wr <= ~oq_wr;
      end
      if (oq_pop) begin
        oq_rd <= ~oq_rd;
      end
      case ({oq_push, oq_pop})
        2'b10:   oq_count <= oq_count + 2'd1;
        2'b01:   oq_count <= oq_count - 2'd1;
        default: oq_count <= oq_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_char[oq_wr] <= push_char;
      oq_last[oq_wr] <= push_last;
    end
  end

endmodule

// ----- sv/signed_binary_to_decimal_ascii.sv -----
// Signed 64-bit integer to decimal ASCII text.
// Input channel: drive value and raise push; a beat is taken on a rising edge
// with push high and full low. The front stage splits sign and magnitude and
// holds up to two waiting numbers, so full only rises when both are taken.
// Result channel: while empty is low, character/last show the oldest waiting
// beat; it leaves on a rising edge with pop high. Each number gives a minus
// sign if negative, then its digits most significant first, no leading zeros;
// last marks the final digit. Zero gives one beat, the most negative value 20.
// Timing: the back stage converts one number at a time with a shift-and-add-3
// loop, one magnitude bit per cycle: it picks the number up, runs the conversion
// over all 64 magnitude bits, locates the leading digit, then emits the
// characters one by one (1 to 20), holding while the output queue is full.
// A new number is picked up only once the last character of the previous one
// has entered the output queue.
// Stalls: with pop low the two-beat output queue fills and the back stage
// holds its current character; the front queue keeps accepting up to two.
// Reset (rst, synchronous) empties both queues and idles the converter.
module signed_binary_to_decimal_ascii (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic signed [63:0]            value,
  output logic                          empty,
  input  logic                          pop,
  output logic [sdta_pkg::CHAR_W-1:0]   character,
  output logic                          last
);
  import sdta_pkg::*;

  logic     item_valid;
  fr_item_t item;
  logic     take;

  // Front: accept and classify, queue two numbers.
  sdta_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .value      (value),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  // Back: convert to BCD, emit characters into the output queue.
  sdta_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .empty      (empty),
    .pop        (pop),
    .character  (character),
    .last       (last)
  );

  // A shown beat is always a minus sign or a decimal digit.
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (character == ASCII_MINUS ||
                (character >= ASCII_ZERO && character <= ASCII_ZERO + CHAR_W'(9))))
    else $error("character outside the ASCII digit and minus set");

  // A minus sign never ends a number.
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && character == ASCII_MINUS) |-> !last)
    else $error("minus sign flagged as last");

  // The converter only picks up a number the front stage holds.
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    take |-> item_valid)
    else $error("back stage took from an empty front queue");

endmodule
